@@ sv/mds_pkg.sv @@
// mds_pkg: shared types and constants of the multibyte delimiter splitter
// no dependencies; imported by the splitter and its output buffer

package mds_pkg;

  localparam int unsigned SEP_MAX_DEF = 8;
  localparam int unsigned SEP_LEN_W   = 4;
  localparam int unsigned SEP_BYTES_W = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = SEP_BYTES_W;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 1'd1;

  localparam logic [SEP_LEN_W-1:0]   SEP_LEN_RST   = 4'd1;
  localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RST = 64'd59;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_byte;
    logic       token_end;
    logic       string_end;
    logic       run_last;
  } res_t;

endpackage

@@ sv/mds_if.sv @@
// mds_in_if and mds_out_if: valid/ready channels of the splitter
// standalone; used by multibyte_delimiter_splitter

interface mds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       string_last;

  modport source (output valid, output in_byte, output byte_present, output string_last,
                  input ready);
  modport sink   (input valid, input in_byte, input byte_present, input string_last,
                  output ready);
endinterface

interface mds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       carries_byte;
  logic       token_end;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output carries_byte, output token_end,
                  output string_end, output run_last, input ready);
  modport sink   (input valid, input out_byte, input carries_byte, input token_end,
                  input string_end, input run_last, output ready);
endinterface

@@ sv/mds_out_fifo.sv @@
// mds_out_fifo: two-entry result buffer between the split step and the output
// depends on mds_pkg (res_t)

module mds_out_fifo
  import mds_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output res_t data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/multibyte_delimiter_splitter.sv @@
// multibyte_delimiter_splitter: top level, configuration registers and split step
// depends on mds_pkg, mds_in_if, mds_out_if and mds_out_fifo

// Splits a byte stream into tokens at a separator of up to SEP_MAX bytes
// (sep_len, sep_bytes with the first character in the lowest byte; a length of
// zero disables splitting, lengths above SEP_MAX act as SEP_MAX). Requests are
// taken one per cycle while the output buffer has room and each causes at most
// one result, as every byte inside a string does unless the separator length
// was lowered below the number of pending bytes. A request causing k results,
// such as a string's closing one (its pending bytes and the end marker), holds
// the input until all are emitted; the split step emits one result per cycle
// while the two-entry buffer has room, so a stalled output is absorbed for two
// results before the input stalls. Write configuration only while idle.

module multibyte_delimiter_splitter
  import mds_pkg::*;
#(
  parameter int unsigned SEP_MAX = SEP_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mds_in_if.sink                in_i,
  mds_out_if.source             out_o
);

  localparam int unsigned CNT_W = $clog2(SEP_MAX + 1);

  logic [SEP_LEN_W-1:0]   sep_len_q;
  logic [SEP_BYTES_W-1:0] sep_bytes_q;
  logic [CNT_W-1:0]       len;

  logic [7:0]       win_q [SEP_MAX];
  logic [CNT_W-1:0] cnt_q;
  logic             cmp_q;
  logic             last_q;
  logic             busy;

  logic [7:0]       v_win [SEP_MAX];
  logic [CNT_W-1:0] v_cnt;
  logic             v_cmp, v_last;
  logic [7:0]       n_win [SEP_MAX];
  logic [CNT_W-1:0] n_cnt;
  logic             n_cmp, n_last, n_cmp_live;
  logic             cmp_live, match, emit;
  res_t             res;

  logic full, in_acc, step_go;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_len_q   <= SEP_LEN_RST;
      sep_bytes_q <= SEP_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEP_LEN:   sep_len_q   <= cfg_data_i[SEP_LEN_W-1:0];
        REG_SEP_BYTES: sep_bytes_q <= cfg_data_i[SEP_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (sep_len_q > SEP_LEN_W'(SEP_MAX)) ? CNT_W'(SEP_MAX)
                                                  : sep_len_q[CNT_W-1:0];

  assign busy     = cmp_q || last_q;
  assign in_acc   = in_i.valid && !busy && !full;
  assign in_i.ready = !busy && !full;
  assign step_go  = !full && (busy || in_acc);

  always_comb begin
    v_win  = win_q;
    v_cnt  = cnt_q;
    v_cmp  = cmp_q;
    v_last = last_q;
    if (in_acc) begin
      for (int i = 0; i < SEP_MAX; i++) begin
        if (in_i.byte_present && (CNT_W'(i) == cnt_q)) begin
          v_win[i] = in_i.in_byte;
        end
      end
      if (in_i.byte_present) begin
        v_cnt = cnt_q + CNT_W'(1);
      end
      v_cmp  = in_i.byte_present;
      v_last = in_i.string_last;
    end

    match = 1'b1;
    for (int i = 0; i < SEP_MAX; i++) begin
      if ((CNT_W'(i) < len) && (v_win[i] != sep_bytes_q[8*i +: 8])) begin
        match = 1'b0;
      end
    end

    cmp_live = v_cmp && ((v_cnt > len) || ((v_cnt == len) && (len != '0)));

    n_win  = v_win;
    n_cnt  = v_cnt;
    n_cmp  = v_cmp;
    n_last = v_last;
    res    = '0;
    emit   = 1'b0;

    if (cmp_live) begin
      emit = 1'b1;
      if ((v_cnt == len) && match) begin
        res.token_end = 1'b1;
        n_cnt = '0;
        n_cmp = 1'b0;
      end else begin
        res.out_byte     = v_win[0];
        res.carries_byte = 1'b1;
        for (int i = 0; i < SEP_MAX - 1; i++) begin
          n_win[i] = v_win[i+1];
        end
        n_cnt = v_cnt - CNT_W'(1);
        if (v_cnt == len) begin
          n_cmp = 1'b0;
        end
      end
    end else begin
      n_cmp = 1'b0;
      if (v_last) begin
        emit = 1'b1;
        if (v_cnt != '0) begin
          res.out_byte     = v_win[0];
          res.carries_byte = 1'b1;
          for (int i = 0; i < SEP_MAX - 1; i++) begin
            n_win[i] = v_win[i+1];
          end
          n_cnt = v_cnt - CNT_W'(1);
        end else begin
          res.token_end  = 1'b1;
          res.string_end = 1'b1;
          n_last = 1'b0;
        end
      end
    end

    n_cmp_live   = n_cmp && ((n_cnt > len) || ((n_cnt == len) && (len != '0)));
    res.run_last = !(n_cmp_live || n_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cmp_q  <= 1'b0;
      last_q <= 1'b0;
    end else if (step_go) begin
      cnt_q  <= n_cnt;
      cmp_q  <= n_cmp_live;
      last_q <= n_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      win_q <= n_win;
    end
  end

  res_t fifo_data;

  mds_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_go && emit),
    .data_i  (res),
    .pop_i   (out_o.ready),
    .full_o  (full),
    .valid_o (out_o.valid),
    .data_o  (fifo_data)
  );

  assign out_o.out_byte     = fifo_data.out_byte;
  assign out_o.carries_byte = fifo_data.carries_byte;
  assign out_o.token_end    = fifo_data.token_end;
  assign out_o.string_end   = fifo_data.string_end;
  assign out_o.run_last     = fifo_data.run_last;

endmodule

@@ sv/mds_checker.sv @@
// mds_checker: port-level assertions of the splitter and their bind
// depends on multibyte_delimiter_splitter port names

module mds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       carries_byte,
  input logic       token_end,
  input logic       string_end,
  input logic       run_last
);

  logic [11:0] out_bundle;
  assign out_bundle = {out_byte, carries_byte, token_end, string_end, run_last};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_bundle))
    else $error("stalled result changed");

  a_string_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && string_end |-> token_end && !carries_byte && run_last)
    else $error("end of string not a closing marker");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !carries_byte |-> out_byte == 8'd0 && token_end)
    else $error("marker carries a byte value");

endmodule

bind multibyte_delimiter_splitter mds_checker u_mds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_byte     (out_o.out_byte),
  .carries_byte (out_o.carries_byte),
  .token_end    (out_o.token_end),
  .string_end   (out_o.string_end),
  .run_last     (out_o.run_last)
);
